// ===== hw/rtl/sbtl_pkg.sv =====
// Shared types, constants and face table for the swept box target clip block.
package sbtl_pkg;

   localparam int WIDE_W = 52;
   localparam int MAG_W  = WIDE_W - 1;
   localparam int DV_W   = 16;
   localparam int GAP_W  = 36;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [GAP_W-1:0]  gap_type;
   typedef logic signed [DV_W:0]     delta_type;
   typedef logic [1:0]               axis_type;
   typedef logic [2:0]               face_type;

   typedef struct packed {
      logic      start;
      wide_type  dividend;
      delta_type divisor;
   } div_req_type;

   localparam axis_type AX_X = 2'd0;
   localparam axis_type AX_Y = 2'd1;
   localparam axis_type AX_Z = 2'd2;

   localparam face_type LAST_FACE = 3'd5;

   localparam logic [1:0] REG_MOVER_MASK   = 2'd0;
   localparam logic [1:0] REG_HALF_EXTENT  = 2'd1;
   localparam logic [1:0] REG_DEFAULT_KIND = 2'd2;

   localparam logic signed [13:0] NORM_POS  = 14'sd4096;
   localparam logic signed [13:0] NORM_NEG  = -14'sd4096;
   localparam logic signed [13:0] NORM_NONE = 14'sd0;
   localparam logic signed [15:0] ID_NONE   = -16'sd1;

   // face axis order: Y low, Y high, Z low, Z high, X low, X high
   function automatic axis_type face_a(face_type f);
      axis_type a;
      case (f)
         3'd0, 3'd1: a = AX_Y;
         3'd2, 3'd3: a = AX_Z;
         default:    a = AX_X;
      endcase
      return a;
   endfunction

   function automatic axis_type face_b(face_type f);
      return (face_a(f) == AX_X) ? AX_Y : AX_X;
   endfunction

   function automatic axis_type face_c(face_type f);
      return (face_a(f) == AX_Z) ? AX_Y : AX_Z;
   endfunction

endpackage

// ===== hw/rtl/sbtl_div.sv =====
// Bit-serial restoring signed divider, one quotient bit per cycle, truncating.
module sbtl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sbtl_pkg::div_req_type div_req,
   output logic                  done,
   output sbtl_pkg::wide_type    quotient
);
   import sbtl_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DV_W-1:0]  rem_ff;
   logic [MAG_W-1:0] quo_ff;
   logic [DV_W-1:0]  dvs_ff;
   logic             neg_ff;

   wide_type         dd_abs_in;
   delta_type        dv_abs_in;
   logic [DV_W:0]    rem_sh_in;
   logic             ge_in;
   logic [DV_W:0]    rem_nx_in;

   always_comb begin
      dd_abs_in = div_req.dividend[WIDE_W-1] ? -div_req.dividend : div_req.dividend;
      dv_abs_in = div_req.divisor[DV_W] ? -div_req.divisor : div_req.divisor;
      rem_sh_in = {rem_ff, quo_ff[MAG_W-1]};
      ge_in     = rem_sh_in >= {1'b0, dvs_ff};
      rem_nx_in = ge_in ? rem_sh_in - {1'b0, dvs_ff} : rem_sh_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (div_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MAG_W - 1);
            rem_ff  <= '0;
            quo_ff  <= dd_abs_in[MAG_W-1:0];
            dvs_ff  <= dv_abs_in[DV_W-1:0];
            neg_ff  <= div_req.dividend[WIDE_W-1] ^ div_req.divisor[DV_W];
         end else if (busy_ff) begin
            rem_ff <= rem_nx_in[DV_W-1:0];
            quo_ff <= {quo_ff[MAG_W-2:0], ge_in};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -wide_type'({1'b0, quo_ff}) : wide_type'({1'b0, quo_ff});

endmodule

// ===== hw/rtl/swept_box_target_list_clip.sv =====
// Top level: swept box clipped against a stream of target boxes.
//
//   channel | direction | beat
//   req_    | in        | begin move or one target box
//   rsp_    | out       | running contact after each item
//   csr_    | in        | register write, no wait
//
// A target beat can be dropped before the faces; it is longest when every face
// runs both offsets through the serial multiplier and the shared serial divider
// (51 quotient bits), which set the pace.
// Reset is synchronous and clears the contact to its empty state.
// One result register decouples rsp_: a finished beat stalls only if the
// previous result still waits.
module swept_box_target_list_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_coord_a_x,
   input  logic signed [31:0] req_coord_a_y,
   input  logic signed [31:0] req_coord_a_z,
   input  logic signed [31:0] req_coord_b_x,
   input  logic signed [31:0] req_coord_b_y,
   input  logic signed [31:0] req_coord_b_z,
   input  logic signed [15:0] req_target_dy,
   input  logic [15:0]        req_target_mask,
   input  logic [3:0]         req_target_kind,
   input  logic signed [15:0] req_target_id,
   input  logic               req_target_active,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_contact_hit,
   output logic [3:0]         rsp_contact_kind,
   output logic signed [15:0] rsp_contact_id,
   output logic signed [13:0] rsp_normal_x,
   output logic signed [13:0] rsp_normal_y,
   output logic signed [13:0] rsp_normal_z,
   output logic signed [31:0] rsp_end_x,
   output logic signed [31:0] rsp_end_y,
   output logic signed [31:0] rsp_end_z,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import sbtl_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_OVL  = 3'd1;
   localparam logic [2:0] S_FACE = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_CHK  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]         state_ff;
   logic [15:0]        mask_ff;
   logic [15:0]        he_ff;
   logic [3:0]         dkind_ff;

   logic signed [31:0] start_ff [3];
   logic signed [31:0] end_ff [3];
   logic signed [13:0] norm_ff [3];
   logic               hit_ff;
   logic [3:0]         kind_ff;
   logic signed [15:0] id_ff;

   logic signed [31:0] bmin_ff [3];
   logic signed [31:0] bmax_ff [3];
   logic signed [15:0] dy_ff;
   logic [3:0]         tkind_ff;
   logic signed [15:0] tid_ff;

   wide_type           lo_ff [3];
   wide_type           hi_ff [3];
   delta_type          d_ff [3];
   axis_type           axis_ff;
   face_type           face_ff;
   logic               sub_ff;
   wide_type           plane_ff;
   gap_type            gap_ff;
   wide_type           prod_ff;
   wide_type           mcand_ff;
   delta_type          mplr_ff;
   logic [4:0]         mcnt_ff;
   wide_type           tb_ff;
   wide_type           q_ff;
   logic               div_start_ff;

   logic               rsp_valid_ff;
   logic               o_hit_ff;
   logic [3:0]         o_kind_ff;
   logic signed [15:0] o_id_ff;
   logic signed [13:0] o_norm_ff [3];
   logic signed [31:0] o_end_ff [3];

   div_req_type        div_req;
   logic               div_done;
   wide_type           div_quo;

   wide_type           p_in, q_in, he_in, mlo_in, mhi_in, bmin_in, bmax_in;
   logic               ovl_fail_in;
   logic [15:0]        d16_in;
   delta_type          d_in;
   axis_type           fa_in, fb_in, fc_in, oth_in;
   logic               low_in;
   wide_type           plane_in, pa_in;
   logic               skip_in;
   wide_type           lob_in, hib_in;
   logic               chk_fail_in;
   logic               consider_in;
   logic               mul_last_in;
   wide_type           mul_add_in;
   logic               rsp_load_in;

   always_comb begin
      he_in   = wide_type'(he_ff);
      p_in    = wide_type'(start_ff[axis_ff]);
      q_in    = wide_type'(end_ff[axis_ff]);
      bmin_in = wide_type'(bmin_ff[axis_ff]);
      bmax_in = wide_type'(bmax_ff[axis_ff]);
      mlo_in  = ((p_in < q_in) ? p_in : q_in) - he_in;
      mhi_in  = ((p_in < q_in) ? q_in : p_in) + he_in;
      ovl_fail_in = (mhi_in < bmin_in) || (bmax_in < mlo_in);
      d16_in  = end_ff[axis_ff][15:0] - start_ff[axis_ff][15:0];
      d_in    = delta_type'($signed(d16_in));
      if (axis_ff == AX_Y) begin
         d_in = d_in - delta_type'(dy_ff);
      end

      fa_in    = face_a(face_ff);
      fb_in    = face_b(face_ff);
      fc_in    = face_c(face_ff);
      low_in   = ~face_ff[0];
      oth_in   = sub_ff ? fc_in : fb_in;
      plane_in = low_in ? lo_ff[fa_in] : hi_ff[fa_in];
      pa_in    = wide_type'(start_ff[fa_in]);
      if (fa_in == AX_Y) begin
         pa_in = pa_in + wide_type'(dy_ff);
      end
      skip_in = low_in ? ((plane_in < pa_in) || (d_ff[fa_in] < 0))
                       : ((pa_in < plane_in) || (d_ff[fa_in] > 0));

      lob_in      = lo_ff[oth_in] - wide_type'(start_ff[oth_in]);
      hib_in      = hi_ff[oth_in] - wide_type'(start_ff[oth_in]);
      chk_fail_in = (q_ff < lob_in) || (hib_in < q_ff);

      consider_in = req_target_active &&
                    ((req_target_mask == '0) || ((req_target_mask & mask_ff) != '0));

      mul_last_in = (mcnt_ff == 5'(DV_W));
      mul_add_in  = mplr_ff[0] ? mcand_ff : '0;
      rsp_load_in = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = d_ff[fa_in];

   sbtl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         he_ff    <= '0;
         dkind_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MOVER_MASK:   mask_ff  <= csr_wdata;
            REG_HALF_EXTENT:  he_ff    <= csr_wdata;
            REG_DEFAULT_KIND: dkind_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
         hit_ff       <= 1'b0;
         kind_ff      <= '0;
         id_ff        <= ID_NONE;
         for (int k = 0; k < 3; k++) begin
            start_ff[k] <= '0;
            end_ff[k]   <= '0;
            norm_ff[k]  <= NORM_NONE;
         end
      end else begin
         div_start_ff <= (state_ff == S_MUL) && mul_last_in && (d_ff[fa_in] != '0);
         rsp_valid_ff <= rsp_load_in || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  bmin_ff[0] <= req_coord_a_x;
                  bmin_ff[1] <= req_coord_a_y;
                  bmin_ff[2] <= req_coord_a_z;
                  bmax_ff[0] <= req_coord_b_x;
                  bmax_ff[1] <= req_coord_b_y;
                  bmax_ff[2] <= req_coord_b_z;
                  dy_ff      <= req_target_dy;
                  tkind_ff   <= req_target_kind;
                  tid_ff     <= req_target_id;
                  axis_ff    <= AX_X;
                  if (!req_action) begin
                     start_ff[0] <= req_coord_a_x;
                     start_ff[1] <= req_coord_a_y;
                     start_ff[2] <= req_coord_a_z;
                     end_ff[0]   <= req_coord_b_x;
                     end_ff[1]   <= req_coord_b_y;
                     end_ff[2]   <= req_coord_b_z;
                     for (int k = 0; k < 3; k++) begin
                        norm_ff[k] <= NORM_NONE;
                     end
                     hit_ff   <= 1'b0;
                     kind_ff  <= dkind_ff;
                     id_ff    <= ID_NONE;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= consider_in ? S_OVL : S_DONE;
                  end
               end
            end
            S_OVL: begin
               lo_ff[axis_ff] <= bmin_in - he_in;
               hi_ff[axis_ff] <= bmax_in + he_in;
               d_ff[axis_ff]  <= d_in;
               if (ovl_fail_in) begin
                  state_ff <= S_DONE;
               end else if (axis_ff == AX_Z) begin
                  face_ff  <= '0;
                  state_ff <= S_FACE;
               end else begin
                  axis_ff <= axis_ff + 1'b1;
               end
            end
            S_FACE: begin
               plane_ff <= plane_in;
               gap_ff   <= GAP_W'(plane_in - pa_in);
               sub_ff   <= 1'b0;
               if (!skip_in) begin
                  mcand_ff <= plane_in - pa_in;
                  mplr_ff  <= d_ff[fb_in];
                  prod_ff  <= '0;
                  mcnt_ff  <= '0;
                  state_ff <= S_MUL;
               end else if (face_ff == LAST_FACE) begin
                  state_ff <= S_DONE;
               end else begin
                  face_ff <= face_ff + 1'b1;
               end
            end
            S_MUL: begin
               prod_ff  <= mul_last_in ? prod_ff - mul_add_in : prod_ff + mul_add_in;
               mcand_ff <= mcand_ff <<< 1;
               mplr_ff  <= mplr_ff >>> 1;
               mcnt_ff  <= mcnt_ff + 1'b1;
               if (mul_last_in) begin
                  if (d_ff[fa_in] == '0) begin
                     q_ff     <= '0;
                     state_ff <= S_CHK;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  q_ff     <= div_quo;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (chk_fail_in) begin
                  if (face_ff == LAST_FACE) begin
                     state_ff <= S_DONE;
                  end else begin
                     face_ff  <= face_ff + 1'b1;
                     state_ff <= S_FACE;
                  end
               end else if (!sub_ff) begin
                  tb_ff    <= q_ff;
                  sub_ff   <= 1'b1;
                  mcand_ff <= wide_type'(gap_ff);
                  mplr_ff  <= d_ff[fc_in];
                  prod_ff  <= '0;
                  mcnt_ff  <= '0;
                  state_ff <= S_MUL;
               end else begin
                  end_ff[fa_in] <= plane_ff[31:0];
                  end_ff[fb_in] <= start_ff[fb_in] + tb_ff[31:0];
                  end_ff[fc_in] <= start_ff[fc_in] + q_ff[31:0];
                  for (int k = 0; k < 3; k++) begin
                     norm_ff[k] <= (axis_type'(k) == fa_in) ?
                                   (low_in ? NORM_POS : NORM_NEG) : NORM_NONE;
                  end
                  hit_ff   <= 1'b1;
                  kind_ff  <= tkind_ff;
                  id_ff    <= tid_ff;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load_in) begin
                  o_hit_ff     <= hit_ff;
                  o_kind_ff    <= kind_ff;
                  o_id_ff      <= id_ff;
                  o_norm_ff    <= norm_ff;
                  o_end_ff     <= end_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_contact_hit  = o_hit_ff;
   assign rsp_contact_kind = o_kind_ff;
   assign rsp_contact_id   = o_id_ff;
   assign rsp_normal_x     = o_norm_ff[0];
   assign rsp_normal_y     = o_norm_ff[1];
   assign rsp_normal_z     = o_norm_ff[2];
   assign rsp_end_x        = o_end_ff[0];
   assign rsp_end_y        = o_end_ff[1];
   assign rsp_end_z        = o_end_ff[2];

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   a_no_hit_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_contact_hit) |->
      (rsp_contact_id == ID_NONE && rsp_normal_x == NORM_NONE &&
       rsp_normal_y == NORM_NONE && rsp_normal_z == NORM_NONE))
      else $error("empty contact carries id or normal");

   a_hit_one_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contact_hit) |->
      $onehot({rsp_normal_x != NORM_NONE, rsp_normal_y != NORM_NONE,
               rsp_normal_z != NORM_NONE}))
      else $error("contact normal not on exactly one axis");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (state_ff == S_DIV))
      else $error("divider started outside divide step");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the swept box target clip block: directed and random moves and target lists.
module tb_top;
   import sbtl_pkg::*;

   localparam longint LIMIT = 8000000;

   typedef struct {
      logic               action;
      logic signed [31:0] ca [3];
      logic signed [31:0] cb [3];
      logic signed [15:0] dy;
      logic [15:0]        mask;
      logic [3:0]         kind;
      logic signed [15:0] id;
      logic               active;
   } beat_t;

   typedef struct {
      logic               hit;
      logic [3:0]         kind;
      logic signed [15:0] id;
      logic signed [13:0] nrm [3];
      logic signed [31:0] pos [3];
   } contact_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_contact_hit;
   logic [3:0] rsp_contact_kind;
   logic signed [15:0] rsp_contact_id;
   logic signed [13:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [31:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic csr_we = 0;
   logic [1:0] csr_index = REG_MOVER_MASK;
   logic [15:0] csr_wdata = 0;

   beat_t cur = '{action: 1'b0, ca: '{0, 0, 0}, cb: '{0, 0, 0}, dy: 0, mask: 0, kind: 0,
                  id: 0, active: 1'b0};
   beat_t pending [$];
   contact_t contact_q [$];
   logic req_took = 0;
   int fails = 0;
   int accepted = 0;
   longint cycles = 0;

   // predictor state
   logic [15:0] cfg_mask = 0;
   logic [15:0] cfg_half = 0;
   logic [3:0]  cfg_kind = 0;
   longint mv_start [3] = '{0, 0, 0};
   longint mv_end [3] = '{0, 0, 0};
   logic        ct_hit = 0;
   logic [3:0]  ct_kind = 0;
   longint      ct_id = -1;
   longint      ct_nrm [3] = '{0, 0, 0};

   swept_box_target_list_clip dut (.*,
      .req_action(cur.action),
      .req_coord_a_x(cur.ca[0]), .req_coord_a_y(cur.ca[1]), .req_coord_a_z(cur.ca[2]),
      .req_coord_b_x(cur.cb[0]), .req_coord_b_y(cur.cb[1]), .req_coord_b_z(cur.cb[2]),
      .req_target_dy(cur.dy), .req_target_mask(cur.mask), .req_target_kind(cur.kind),
      .req_target_id(cur.id), .req_target_active(cur.active));

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic longint wrap32(longint v);
      logic signed [31:0] t;
      t = v[31:0];
      return longint'(t);
   endfunction

   function automatic void clip_target(beat_t b);
      int fa [6] = '{1, 1, 2, 2, 0, 0};
      int fb [6] = '{0, 0, 0, 0, 1, 1};
      int fc [6] = '{2, 2, 1, 1, 2, 2};
      longint lo [3], hi [3], d [3];
      longint he, dyv, mlo, mhi, plane, pa, gap, tb, tc;
      logic signed [15:0] d16;
      bit low;
      int a, bb, c;
      he = longint'(cfg_half);
      dyv = longint'(b.dy);
      if (!b.active) return;
      if (b.mask != 0 && (b.mask & cfg_mask) == 0) return;
      for (int k = 0; k < 3; k++) begin
         mlo = ((mv_start[k] < mv_end[k]) ? mv_start[k] : mv_end[k]) - he;
         mhi = ((mv_start[k] < mv_end[k]) ? mv_end[k] : mv_start[k]) + he;
         if (mhi < longint'(b.ca[k]) || longint'(b.cb[k]) < mlo) return;
         lo[k] = longint'(b.ca[k]) - he;
         hi[k] = longint'(b.cb[k]) + he;
         d16 = 16'(mv_end[k] - mv_start[k]);
         d[k] = longint'(d16);
      end
      d[1] -= dyv;
      for (int f = 0; f < 6; f++) begin
         a = fa[f]; bb = fb[f]; c = fc[f];
         low = (f % 2 == 0);
         plane = low ? lo[a] : hi[a];
         pa = mv_start[a] + ((a == 1) ? dyv : 0);
         if (low ? (plane < pa || d[a] < 0) : (pa < plane || d[a] > 0)) continue;
         gap = plane - pa;
         tb = (d[a] != 0) ? (d[bb] * gap) / d[a] : 0;
         if (tb < lo[bb] - mv_start[bb] || hi[bb] - mv_start[bb] < tb) continue;
         tc = (d[a] != 0) ? (d[c] * gap) / d[a] : 0;
         if (tc < lo[c] - mv_start[c] || hi[c] - mv_start[c] < tc) continue;
         mv_end[a] = wrap32(plane);
         mv_end[bb] = wrap32(mv_start[bb] + tb);
         mv_end[c] = wrap32(mv_start[c] + tc);
         for (int k = 0; k < 3; k++)
            ct_nrm[k] = (k == a) ? (low ? 4096 : -4096) : 0;
         ct_hit = 1;
         ct_kind = b.kind;
         ct_id = longint'(b.id);
         return;
      end
   endfunction

   function automatic contact_t advance_contact(beat_t b);
      contact_t r;
      if (b.action) begin
         clip_target(b);
      end else begin
         for (int k = 0; k < 3; k++) begin
            mv_start[k] = longint'(b.ca[k]);
            mv_end[k] = longint'(b.cb[k]);
            ct_nrm[k] = 0;
         end
         ct_hit = 0;
         ct_kind = cfg_kind;
         ct_id = -1;
      end
      r.hit = ct_hit;
      r.kind = ct_kind;
      r.id = 16'(ct_id);
      for (int k = 0; k < 3; k++) begin
         r.nrm[k] = 14'(ct_nrm[k]);
         r.pos[k] = 32'(mv_end[k]);
      end
      return r;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d actual %0d", name, exp_v, act_v);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      contact_t got, want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      if (reset) begin
         req_took <= 0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            contact_q.push_back(advance_contact(cur));
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got.hit = rsp_contact_hit; got.kind = rsp_contact_kind; got.id = rsp_contact_id;
            got.nrm = '{rsp_normal_x, rsp_normal_y, rsp_normal_z};
            got.pos = '{rsp_end_x, rsp_end_y, rsp_end_z};
            if (contact_q.size() == 0) begin
               $error("result beat with no contact expected");
               fails++;
            end else begin
               want = contact_q.pop_front();
               check_field("contact_hit", want.hit, got.hit);
               check_field("contact_kind", want.kind, got.kind);
               check_field("contact_id", want.id, got.id);
               check_field("normal_x", want.nrm[0], got.nrm[0]);
               check_field("normal_y", want.nrm[1], got.nrm[1]);
               check_field("normal_z", want.nrm[2], got.nrm[2]);
               check_field("end_x", want.pos[0], got.pos[0]);
               check_field("end_y", want.pos[1], got.pos[1]);
               check_field("end_z", want.pos[2], got.pos[2]);
            end
         end
      end
   end

   // sender: bursts with random gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_took) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 0;
      end else if (pending.size() > 0) begin
         cur <= pending.pop_front();
         req_valid <= 1;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_valid <= 0;
      end
   end

   // receiver: stall pattern plus one long hold-off
   int rx_cnt = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      rx_cnt++;
      if (!hold_done && accepted >= 200) begin
         hold_done = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         case ((rx_cnt / 500) % 3)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((rx_cnt % 9) < 4);
         endcase
      end
   end

   function automatic beat_t begin_beat(logic signed [31:0] s [3], logic signed [31:0] e [3]);
      beat_t b;
      b.action = 0; b.ca = s; b.cb = e;
      b.dy = 16'($urandom); b.mask = 16'($urandom); b.kind = 4'($urandom);
      b.id = 16'($urandom);
      b.active = 1'($urandom);
      return b;
   endfunction

   function automatic beat_t target_beat(logic signed [31:0] mn [3], logic signed [31:0] mx [3],
                                        logic signed [15:0] dy, logic [15:0] mask);
      beat_t b;
      b.action = 1; b.ca = mn; b.cb = mx; b.dy = dy; b.mask = mask;
      b.kind = 4'($urandom);
      b.id = ($urandom_range(0, 7) == 0) ? ID_NONE : 16'($urandom_range(0, 32767));
      b.active = 1;
      return b;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MOVER_MASK:  cfg_mask = val;
         REG_HALF_EXTENT: cfg_half = val;
         default:         cfg_kind = val[3:0];
      endcase
   endtask

   task automatic close_write();
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_valid || contact_q.size() > 0)
         @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic queue_move(int span);
      logic signed [31:0] s [3], e [3], mn [3], mx [3], p [3];
      logic signed [15:0] dy;
      logic [15:0] mask;
      int n;
      for (int k = 0; k < 3; k++) begin
         s[k] = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 8000)) - 4000;
         e[k] = s[k] + $urandom_range(0, 2 * span) - span;
      end
      pending.push_back(begin_beat(s, e));
      n = $urandom_range(1, 7);
      for (int t = 0; t < n; t++) begin
         for (int k = 0; k < 3; k++) begin
            p[k] = s[k] + ((e[k] - s[k]) / 8) * $urandom_range(0, 8);
            mn[k] = p[k] - $urandom_range(0, 300);
            mx[k] = p[k] + $urandom_range(0, 300);
         end
         if ($urandom_range(0, 9) == 0) begin
            for (int k = 0; k < 3; k++) begin
               mn[k] = $urandom;
               mx[k] = $urandom;
            end
         end
         dy = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200)) - 100;
         mask = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
         pending.push_back(target_beat(mn, mx, dy, mask));
         if ($urandom_range(0, 11) == 0) begin
            pending[$].active = 0;
         end
      end
   endtask

   initial begin
      logic signed [31:0] z [3], big [3], neg [3], one [3];
      logic [15:0] mask_set [6] = '{16'h0000, 16'hFFFF, 16'h00F0, 16'hFFFF, 16'h0000, 16'h5A5A};
      logic [15:0] half_set [6] = '{16'd0, 16'hFFFF, 16'd40, 16'd7, 16'd300, 16'd0};
      logic [3:0]  kind_set [6] = '{4'd0, 4'd15, 4'd9, 4'd3, 4'd6, 4'd12};
      z = '{0, 0, 0};
      big = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      neg = '{32'h80000000, 32'h80000000, 32'h80000000};
      one = '{10, 10, 10};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed
      pending.push_back(target_beat(z, one, 16'sd0, 16'h0000));
      drain();
      write_reg(REG_MOVER_MASK, 16'h0001);
      write_reg(REG_HALF_EXTENT, 16'd5);
      write_reg(REG_DEFAULT_KIND, 16'd15);
      close_write();
      pending.push_back(begin_beat('{0, 0, 0}, '{100, 50, -40}));
      pending.push_back(target_beat('{20, -30, -30}, '{40, 60, 30}, 16'sd0, 16'h0002));
      pending[$].active = 1;
      pending.push_back(target_beat('{20, -30, -30}, '{40, 60, 30}, 16'sd0, 16'h0000));
      pending[$].active = 0;
      pending.push_back(target_beat('{20, -30, -30}, '{40, 60, 30}, 16'sd0, 16'h0003));
      pending.push_back(target_beat('{60, 20, -60}, '{80, 90, 0}, 16'sh7FFF, 16'h0000));
      pending.push_back(target_beat('{60, 20, -60}, '{80, 90, 0}, 16'sh8000, 16'h0000));
      pending.push_back(target_beat('{40, 40, 40}, '{-40, -40, -40}, 16'sd0, 16'h0000));
      pending.push_back(begin_beat('{5, 5, 5}, '{5, 5, 5}));
      pending.push_back(target_beat('{0, 0, 0}, '{10, 10, 10}, 16'sd0, 16'h0000));
      pending.push_back(target_beat('{0, 0, 0}, '{10, 10, 10}, 16'sd3, 16'h0000));
      pending.push_back(begin_beat(neg, big));
      pending.push_back(target_beat(neg, big, 16'sh8000, 16'hFFFF));
      pending.push_back(target_beat('{-100, -100, -100}, '{100, 100, 100}, 16'sd0, 16'h0000));
      pending.push_back(begin_beat(big, neg));
      pending.push_back(target_beat(neg, big, 16'sh7FFF, 16'h0000));
      pending.push_back(begin_beat('{0, 0, 0}, '{70000, -70000, 65535}));
      pending.push_back(target_beat('{200, -600, 200}, '{900, -100, 900}, 16'sd0, 16'h0000));
      drain();
      write_reg(REG_DEFAULT_KIND, 16'd4);
      close_write();
      pending.push_back(target_beat('{-200, -200, -200}, '{200, 200, 200}, 16'sd0, 16'h0000));
      pending.push_back(begin_beat(z, '{50, 50, 50}));
      drain();

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_MOVER_MASK, mask_set[ph]);
         write_reg(REG_HALF_EXTENT, half_set[ph]);
         write_reg(REG_DEFAULT_KIND, 16'(kind_set[ph]));
         close_write();
         while (pending.size() < 240)
            queue_move(($urandom_range(0, 9) == 0) ? 80000 : 2000);
         drain();
      end

      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/sbtl_pkg.sv
hw/rtl/sbtl_div.sv
hw/rtl/swept_box_target_list_clip.sv
tb/sv/tb_top.sv
